/* rtl/multiwave_lfo_oscillator_defines.svh */
// assertion macros for the multiwave lfo oscillator
// no dependencies; included by the modules that carry assertions
`ifndef MULTIWAVE_LFO_OSCILLATOR_DEFINES_SVH
`define MULTIWAVE_LFO_OSCILLATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MLFO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mlfo assertion failed");

// next-cycle implication, disabled while reset is low
`define MLFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mlfo assertion failed");

`endif

/* rtl/mlfo_pkg.sv */
// shared types, constants and the sine table generator for the lfo
// no dependencies
package mlfo_pkg;

    localparam int unsigned DEF_PHASE_BITS     = 32;
    localparam int unsigned DEF_OUT_BITS       = 16;
    localparam int unsigned DEF_SINE_ADDR_BITS = 10;

    localparam int unsigned START_BITS    = 32;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned INC_BITS      = 32;
    localparam int unsigned WAVE_BITS     = 2;

    localparam logic [INC_BITS-1:0] INC_RESET = 32'd89478;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // taylor series denominators, highest order first
    localparam int unsigned TaylorDiv [6] = '{156, 110, 72, 42, 20, 6};

    typedef enum logic [0:0] {
        CFG_PHASE_INC = 1'b0,
        CFG_WAVE_SEL  = 1'b1
    } t_cfg_idx;

    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_SINE = 2'd0,
        WAVE_SAW  = 2'd1,
        WAVE_TRI  = 2'd2
    } t_wave;

    // quarter-wave sine entry k of 2^addr_bits, evaluated at elaboration only
    function automatic logic [63:0] sine_entry(input int unsigned k,
                                               input int unsigned addr_bits,
                                               input int unsigned out_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] fs;
        x  = ((64'(k) * Q30_HALF_PI) + (64'd1 << (addr_bits - 1))) >> addr_bits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int j = 0; j < 6; j++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / 64'(TaylorDiv[j]));
        end
        s  = (x * t) >> 30;
        fs = 64'd1 << (out_bits - 1);
        v  = (s * fs + (Q30_ONE >> 1)) >> 30;
        if (v > fs - 64'd1) begin
            v = fs - 64'd1;
        end
        return v;
    endfunction

endpackage

/* rtl/mlfo_sine_rom.sv */
// quarter-wave sine rom with registered read, contents built at elaboration
// depends on mlfo_pkg
module mlfo_sine_rom
    import mlfo_pkg::*;
#(
    parameter int unsigned ADDR_BITS = DEF_SINE_ADDR_BITS,
    parameter int unsigned DATA_BITS = DEF_OUT_BITS - 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ADDR_BITS:0]   i_addr,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

    logic [DATA_BITS-1:0] rom [DEPTH];
    logic [DATA_BITS-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam logic [63:0] VAL = sine_entry(g, ADDR_BITS, DATA_BITS + 1);
        assign rom[g] = VAL[DATA_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/multiwave_lfo_oscillator.sv */
// Phase accumulator lfo with sine, saw and triangle output. Takes one
// transaction per clock while o_stall is low; a tick result reaches the output
// through the stage 1 phase register, the sine rom registered read and the output
// register, and a load transaction only sets the phase and yields no result.
// Throughput is one transaction per cycle while o_stall is low, set by the single
// phase adder; an empty stage keeps moving while the output side stalls, and
// i_stall reaches o_stall in the same cycle only when all three stages hold data.
// depends on mlfo_pkg, mlfo_sine_rom and multiwave_lfo_oscillator_defines.svh
`include "multiwave_lfo_oscillator_defines.svh"

module multiwave_lfo_oscillator
    import mlfo_pkg::*;
#(
    parameter int unsigned PHASE_BITS           = DEF_PHASE_BITS,
    parameter int unsigned OUT_BITS             = DEF_OUT_BITS,
    parameter int unsigned SINE_TABLE_ADDR_BITS = DEF_SINE_ADDR_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_op,
    input  logic [START_BITS-1:0]    i_start_phase,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [OUT_BITS-1:0]      o_sample_value
);

    localparam int unsigned SA = SINE_TABLE_ADDR_BITS;
    localparam int unsigned WW = PHASE_BITS + OUT_BITS + 1;

    localparam logic [OUT_BITS-1:0]   POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS:0]     FS_EXT  = {2'b01, {(OUT_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS-1:0] HALF_P  = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [SA:0]           TBL_N   = {1'b1, {SA{1'b0}}};

    // configuration registers
    logic [INC_BITS-1:0]  r_phase_inc;
    logic [WAVE_BITS-1:0] r_wave_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= INC_RESET;
            r_wave_sel  <= WAVE_SINE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PHASE_INC: r_phase_inc <= i_cfg_data[INC_BITS-1:0];
                CFG_WAVE_SEL:  r_wave_sel  <= i_cfg_data[WAVE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic en1, en2, en3, in_accept;
    logic r_s1_valid, r_s2_valid, r_out_valid;

    assign en3       = !r_out_valid || !i_stall;
    assign en2       = !r_s2_valid || en3;
    assign en1       = !r_s1_valid || en2;
    assign o_stall   = !en1;
    assign in_accept = i_valid && en1;

    // phase accumulator
    logic [PHASE_BITS-1:0]          r_phase;
    logic [PHASE_BITS-1:0]          n_phase;
    logic [PHASE_BITS+INC_BITS-1:0] inc_wide;
    logic [PHASE_BITS+START_BITS-1:0] start_wide;
    logic [PHASE_BITS-1:0]          inc_ext;
    logic [PHASE_BITS-1:0]          start_masked;

    assign inc_wide     = {{PHASE_BITS{r_phase_inc[INC_BITS-1]}}, r_phase_inc};
    assign inc_ext      = inc_wide[PHASE_BITS-1:0];
    assign start_wide   = {{PHASE_BITS{1'b0}}, i_start_phase};
    assign start_masked = start_wide[PHASE_BITS-1:0];

    always_comb begin
        n_phase = r_phase;
        if (in_accept) begin
            n_phase = i_op ? start_masked : r_phase + inc_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // stage 1: phase of the tick
    logic [PHASE_BITS-1:0] r_s1_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= in_accept && !i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_phase <= r_phase;
        end
    end

    // stage 1 logic: saw, triangle and sine address
    logic [WW-1:0]         saw_wide;
    logic [WW-1:0]         tri_wide;
    logic [PHASE_BITS-1:0] tri_dist;
    logic [OUT_BITS:0]     tri_top;
    logic [OUT_BITS:0]     tri_diff;
    logic [OUT_BITS-1:0]   saw_val;
    logic [OUT_BITS-1:0]   tri_val;
    logic [OUT_BITS-1:0]   n_lin;
    logic                  n_is_sine;
    logic [SA+1:0]         sine_pos;
    logic [SA:0]           sine_idx;
    logic [SA:0]           rom_addr;

    always_comb begin
        saw_wide = {r_s1_phase, {(OUT_BITS+1){1'b0}}} >> (WW - OUT_BITS);
        saw_val  = {~saw_wide[OUT_BITS-1], saw_wide[OUT_BITS-2:0]};

        tri_dist = (r_s1_phase >= HALF_P) ? r_s1_phase - HALF_P : HALF_P - r_s1_phase;
        tri_wide = {tri_dist, {(OUT_BITS+1){1'b0}}} >> (WW - (OUT_BITS + 1));
        tri_top  = tri_wide[OUT_BITS:0];
        tri_diff = FS_EXT - tri_top;
        // distance zero lands on +1.0, which saturates
        tri_val  = (tri_top == '0) ? POS_MAX : tri_diff[OUT_BITS-1:0];

        n_is_sine = 1'b0;
        case (t_wave'(r_wave_sel))
            WAVE_SINE: begin
                n_lin     = '0;
                n_is_sine = 1'b1;
            end
            WAVE_SAW:  n_lin = saw_val;
            WAVE_TRI:  n_lin = tri_val;
            default:   n_lin = '0;
        endcase

        sine_pos = r_s1_phase[PHASE_BITS-1 -: SA+2];
        sine_idx = {1'b0, sine_pos[SA-1:0]};
        rom_addr = sine_pos[SA] ? TBL_N - sine_idx : sine_idx;
    end

    // stage 2: rom read and linear waveform value
    logic [OUT_BITS-2:0] rom_data;
    logic [OUT_BITS-1:0] r_s2_lin;
    logic                r_s2_is_sine;
    logic                r_s2_neg;

    mlfo_sine_rom #(
        .ADDR_BITS (SA),
        .DATA_BITS (OUT_BITS - 1)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_lin     <= n_lin;
            r_s2_is_sine <= n_is_sine;
            r_s2_neg     <= sine_pos[SA+1];
        end
    end

    // stage 3: output register
    logic [OUT_BITS-1:0] r_sample;
    logic [OUT_BITS-1:0] sine_mag;
    logic [OUT_BITS-1:0] n_sample;

    always_comb begin
        sine_mag = {1'b0, rom_data};
        if (r_s2_is_sine) begin
            n_sample = r_s2_neg ? -sine_mag : sine_mag;
        end else begin
            n_sample = r_s2_lin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_sample;

    `MLFO_ASSERT_NEXT(a_load_sets_phase, i_clk, i_rst_n, in_accept && i_op, r_phase == $past(start_masked))
    `MLFO_ASSERT_NEXT(a_tick_steps_phase, i_clk, i_rst_n, in_accept && !i_op, r_phase == $past(r_phase + inc_ext))
    `MLFO_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, in_accept && i_op, !r_s1_valid)
    `MLFO_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, o_stall, r_s1_valid && r_s2_valid && r_out_valid)

endmodule
